// ===== hw/rtl/eroc_pkg.sv =====
// ----------------------------------------------------------------------------
// Radii of curvature package
// Widths, constants and the arctangent table shared by the pipeline and its
// checker.
// ----------------------------------------------------------------------------
package eroc_pkg;

  // Number of CORDIC rotation stages (12 to 32).
  localparam int unsigned CORDIC_STAGES = 24;

  localparam int unsigned LAT_W    = 32;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned A_W      = 31;
  localparam int unsigned E2_W     = 32;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 64;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_SEMI_MAJOR_AXIS = 1'b0,
    REG_ECC_SQUARED     = 1'b1
  } cfg_reg_e;

  localparam logic signed [LAT_W-1:0] LAT_LIMIT   = 32'sd1686629713;
  localparam logic signed [33:0]      CORDIC_GAIN = 34'sd652032874;
  localparam logic [A_W-1:0]          A_RESET     = 31'd1632803072;
  localparam logic [E2_W-1:0]         E2_RESET    = 32'd28752143;
  localparam logic [RADIUS_W-1:0]     RADIUS_MAX  = {RADIUS_W{1'b1}};

  // Step counts of the square root and ratio stages and of the prime vertical divider.
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned NDIV_STEPS = 48;

  // floor(atan(2^-i) * 2^30) for the CORDIC angle update.
  function automatic logic signed [33:0] atan_q30(input int unsigned i);
    logic signed [33:0] v;
    begin
      case (i)
        0:  v = 34'sd843314856;
        1:  v = 34'sd497837829;
        2:  v = 34'sd263043836;
        3:  v = 34'sd133525158;
        4:  v = 34'sd67021686;
        5:  v = 34'sd33543515;
        6:  v = 34'sd16775850;
        7:  v = 34'sd8388437;
        8:  v = 34'sd4194282;
        9:  v = 34'sd2097149;
        10: v = 34'sd1048575;
        11: v = 34'sd524287;
        12: v = 34'sd262143;
        13: v = 34'sd131071;
        14: v = 34'sd65535;
        15: v = 34'sd32767;
        16: v = 34'sd16383;
        17: v = 34'sd8191;
        18: v = 34'sd4095;
        19: v = 34'sd2047;
        20: v = 34'sd1023;
        21: v = 34'sd511;
        22: v = 34'sd255;
        23: v = 34'sd127;
        24: v = 34'sd63;
        25: v = 34'sd31;
        26: v = 34'sd15;
        27: v = 34'sd7;
        28: v = 34'sd3;
        29: v = 34'sd1;
        default: v = 34'sd0;
      endcase
      return v;
    end
  endfunction

endpackage

// ===== hw/rtl/earth_radii_of_curvature.sv =====
// Pipeline from an accepted input beat to the result beat on the master side:
// 1 clamp, CORDIC_STAGES CORDIC, 3 squaring, 32 root and ratio,
// 1 numerator, 48 divider, 1 product and 1 output stage.
// Throughput: one beat per cycle; the whole pipeline advances together and
// holds while a result waits on the master side.
// Reset clears all valid bits and loads the WGS84 ellipsoid into the registers.
// ----------------------------------------------------------------------------
// Ellipsoid radii of curvature
// Computes the meridian and prime vertical radii for one geodetic latitude
// through a CORDIC sine, a bit-per-stage square root and restoring dividers.
// ----------------------------------------------------------------------------
module earth_radii_of_curvature (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_idx_i,
  input  logic [eroc_pkg::CFG_W-1:0]           cfg_data_i,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [31:0] latitude
  input  logic [eroc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [30:0] meridian_radius, [61:31] prime_vertical_radius, [63:62] zero
  output logic [eroc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import eroc_pkg::*;

  localparam int unsigned NC = CORDIC_STAGES;

  logic            en;
  logic [A_W-1:0]  a_q;
  logic [E2_W-1:0] e2_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q  <= A_RESET;
      e2_q <= E2_RESET;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_SEMI_MAJOR_AXIS: a_q  <= cfg_data_i[A_W-1:0];
        REG_ECC_SQUARED:     e2_q <= cfg_data_i[E2_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves whenever the output register is free or being drained.
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Clamp and CORDIC rotation.
  // --------------------------------------------------------------------------
  logic signed [33:0] cx_q [0:NC];
  logic signed [33:0] cy_q [0:NC];
  logic signed [33:0] cz_q [0:NC];
  logic               cv_q [0:NC];
  logic signed [LAT_W-1:0] lat;
  logic signed [LAT_W-1:0] lat_clamped;

  assign lat = signed'(s_axis_tdata[LAT_W-1:0]);

  always_comb begin
    if (lat > LAT_LIMIT) begin
      lat_clamped = LAT_LIMIT;
    end else if (lat < -LAT_LIMIT) begin
      lat_clamped = -LAT_LIMIT;
    end else begin
      lat_clamped = lat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cv_q[0] <= 1'b0;
    end else if (en) begin
      cv_q[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q[0] <= CORDIC_GAIN;
      cy_q[0] <= '0;
      cz_q[0] <= 34'(lat_clamped);
    end
  end

  for (genvar i = 0; i < NC; i++) begin : g_cordic
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    assign dx = cy_q[i] >>> i;
    assign dy = cx_q[i] >>> i;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cv_q[i+1] <= 1'b0;
      end else if (en) begin
        cv_q[i+1] <= cv_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        if (!cz_q[i][33]) begin
          cx_q[i+1] <= cx_q[i] - dx;
          cy_q[i+1] <= cy_q[i] + dy;
          cz_q[i+1] <= cz_q[i] - atan_q30(i);
        end else begin
          cx_q[i+1] <= cx_q[i] + dx;
          cy_q[i+1] <= cy_q[i] - dy;
          cz_q[i+1] <= cz_q[i] + atan_q30(i);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sine magnitude, its square and w2 = 1 - e2 * sin^2.
  // --------------------------------------------------------------------------
  logic [33:0] y_abs;
  logic [30:0] u_q;
  logic [32:0] s2_q;
  logic [32:0] w2_q;
  logic [61:0] u_sq;
  logic [64:0] e2_s2;
  logic        u_v_q, s2_v_q, w2_v_q;

  assign y_abs = cy_q[NC][33] ? 34'(-cy_q[NC]) : 34'(cy_q[NC]);
  assign u_sq  = 62'(u_q) * 62'(u_q);
  assign e2_s2 = 65'(e2_q) * 65'(s2_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      u_v_q  <= 1'b0;
      s2_v_q <= 1'b0;
      w2_v_q <= 1'b0;
    end else if (en) begin
      u_v_q  <= cv_q[NC];
      s2_v_q <= u_v_q;
      w2_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q  <= (y_abs > 34'd1073741824) ? 31'd1073741824 : y_abs[30:0];
      s2_q <= u_sq[60:28];
      w2_q <= 33'h1_0000_0000 - {1'b0, e2_s2[63:32]};
    end
  end

  // --------------------------------------------------------------------------
  // Square root of w2 * 2^28, one result bit a stage but the last, alongside the
  // ratio r = (1 - e2) * 2^31 / w2, one quotient bit a stage.
  // --------------------------------------------------------------------------
  logic [61:0] sr_rem_q  [1:SQRT_STEPS];
  logic [30:0] sr_root_q [1:SQRT_STEPS];
  logic [63:0] rd_rem_q  [1:SQRT_STEPS];
  logic [31:0] rd_q_q    [1:SQRT_STEPS];
  logic [32:0] rd_w2_q   [1:SQRT_STEPS];
  logic        sr_v_q    [1:SQRT_STEPS];
  logic [32:0] one_minus_e2;

  assign one_minus_e2 = 33'h1_0000_0000 - {1'b0, e2_q};

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam int unsigned J = SQRT_STEPS - 1 - k;
    logic [61:0] sr_rem;
    logic [30:0] sr_root;
    logic [63:0] rd_rem;
    logic [31:0] rd_quo;
    logic [32:0] rd_w2;
    logic        sr_v;
    logic [61:0] sr_rem_d;
    logic [30:0] sr_root_d;
    logic [63:0] rd_hi;
    logic [63:0] rd_sub;

    // The first stage starts from w2 and the ratio numerator.
    if (k == 0) begin : g_first
      assign sr_rem  = {1'b0, w2_q, 28'd0};
      assign sr_root = '0;
      assign rd_rem  = {one_minus_e2, 31'd0};
      assign rd_quo  = '0;
      assign rd_w2   = w2_q;
      assign sr_v    = w2_v_q;
    end else begin : g_next
      assign sr_rem  = sr_rem_q[k];
      assign sr_root = sr_root_q[k];
      assign rd_rem  = rd_rem_q[k];
      assign rd_quo  = rd_q_q[k];
      assign rd_w2   = rd_w2_q[k];
      assign sr_v    = sr_v_q[k];
    end

    if (k < 31) begin : g_bit
      localparam int unsigned B = 30 - k;
      logic [61:0] trial;
      assign trial = (62'(sr_root) << (B + 1)) | (62'd1 << (2 * B));
      always_comb begin
        if (sr_rem >= trial) begin
          sr_rem_d  = sr_rem - trial;
          sr_root_d = sr_root | (31'd1 << B);
        end else begin
          sr_rem_d  = sr_rem;
          sr_root_d = sr_root;
        end
      end
    end else begin : g_pass
      assign sr_rem_d  = sr_rem;
      assign sr_root_d = sr_root;
    end

    assign rd_hi  = rd_rem >> J;
    assign rd_sub = 64'(rd_w2) << J;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sr_v_q[k+1] <= 1'b0;
      end else if (en) begin
        sr_v_q[k+1] <= sr_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        sr_rem_q[k+1]  <= sr_rem_d;
        sr_root_q[k+1] <= sr_root_d;
        rd_w2_q[k+1]   <= rd_w2;
        if (rd_hi >= 64'(rd_w2)) begin
          rd_rem_q[k+1] <= rd_rem - rd_sub;
          rd_q_q[k+1]   <= rd_quo | (32'd1 << J);
        end else begin
          rd_rem_q[k+1] <= rd_rem;
          rd_q_q[k+1]   <= rd_quo;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Prime vertical radius N = (a * 2^30 + w/2) / w, one quotient bit a stage.
  // --------------------------------------------------------------------------
  logic [61:0] nd_rem_q [0:NDIV_STEPS];
  logic [47:0] nd_q_q   [0:NDIV_STEPS];
  logic [30:0] nd_w_q   [0:NDIV_STEPS];
  logic [31:0] nd_r_q   [0:NDIV_STEPS];
  logic        nd_v_q   [0:NDIV_STEPS];
  logic [30:0] w_root;

  assign w_root = sr_root_q[SQRT_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nd_v_q[0] <= 1'b0;
    end else if (en) begin
      nd_v_q[0] <= sr_v_q[SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      nd_rem_q[0] <= {a_q, 30'd0} + 62'(w_root >> 1);
      nd_q_q[0]   <= '0;
      nd_w_q[0]   <= w_root;
      nd_r_q[0]   <= rd_q_q[SQRT_STEPS];
    end
  end

  for (genvar k = 0; k < NDIV_STEPS; k++) begin : g_ndiv
    localparam int unsigned J = NDIV_STEPS - 1 - k;
    logic [61:0] hi;
    logic [61:0] sub;
    assign hi  = nd_rem_q[k] >> J;
    assign sub = 62'(78'(nd_w_q[k]) << J);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        nd_v_q[k+1] <= 1'b0;
      end else if (en) begin
        nd_v_q[k+1] <= nd_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        nd_w_q[k+1] <= nd_w_q[k];
        nd_r_q[k+1] <= nd_r_q[k];
        if (hi >= 62'(nd_w_q[k])) begin
          nd_rem_q[k+1] <= nd_rem_q[k] - sub;
          nd_q_q[k+1]   <= nd_q_q[k] | (48'd1 << J);
        end else begin
          nd_rem_q[k+1] <= nd_rem_q[k];
          nd_q_q[k+1]   <= nd_q_q[k];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Meridian radius M = N * r / 2^31 from two partial products.
  // --------------------------------------------------------------------------
  logic [47:0] nf;
  logic [63:0] phi_q;
  logic [47:0] plo_q;
  logic [47:0] nf_q;
  logic        pr_v_q;
  logic [48:0] low_sum;
  logic [48:0] mf;
  logic [RADIUS_W-1:0] m_rad;
  logic [RADIUS_W-1:0] n_rad;

  assign nf = nd_q_q[NDIV_STEPS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pr_v_q <= 1'b0;
    end else if (en) begin
      pr_v_q <= nd_v_q[NDIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      phi_q <= 64'(nf[47:16]) * 64'(nd_r_q[NDIV_STEPS]);
      plo_q <= 48'(nf[15:0]) * 48'(nd_r_q[NDIV_STEPS]);
      nf_q  <= nf;
    end
  end

  assign low_sum = {18'd0, phi_q[14:0], 16'd0} + {1'b0, plo_q};
  assign mf      = phi_q[63:15] + 49'(low_sum[48:31]);
  assign m_rad   = (mf > 49'(RADIUS_MAX)) ? RADIUS_MAX : mf[RADIUS_W-1:0];
  assign n_rad   = (nf_q > 48'(RADIUS_MAX)) ? RADIUS_MAX : nf_q[RADIUS_W-1:0];

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= pr_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      m_axis_tdata <= {2'b00, n_rad, m_rad};
    end
  end

endmodule

// ===== hw/rtl/eroc_checker.sv =====
// ----------------------------------------------------------------------------
// Radii of curvature checker
// Port-level assertions for the radii pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module eroc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [eroc_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import eroc_pkg::*;

  // A result beat stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat withdrawn under stall");

  // The input side is open whenever no result is waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("input stalled with a free output register");

  // The meridian radius never exceeds the prime vertical radius.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[30:0] <= m_axis_tdata[61:31])
    else $error("meridian radius above prime vertical radius");

  // The padding bits of a result beat are zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[63:62] == 2'b00)
    else $error("result padding not zero");

endmodule

bind earth_radii_of_curvature eroc_checker u_eroc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
